// ----- design/dmbc_pkg.sv -----
package dmbc_pkg;

    localparam int COUNT_WIDTH_DEFAULT = 8;
    localparam int CFG_DATA_W          = 8;
    localparam int CFG_INDEX_W         = 2;
    localparam int BUS_MODE_W          = 8;

    localparam logic [CFG_DATA_W-1:0] LONG_PRESS_RESET = 8'd30;
    localparam logic [CFG_DATA_W-1:0] DEBOUNCE_RESET   = 8'd5;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_LONG_PRESS = 2'd0,
        CFG_DEBOUNCE   = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        OP_TICK     = 2'd0,
        OP_ESTOP    = 2'd1,
        OP_SET_MODE = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        MODE_MANUAL = 2'd0,
        MODE_AUTO   = 2'd1,
        MODE_ESTOP  = 2'd2
    } mode_t;

    typedef struct packed {
        logic [1:0]            operation;
        logic                  mode_button;
        logic                  start_button;
        logic [BUS_MODE_W-1:0] bus_mode;
    } in_item_t;

    typedef struct packed {
        logic [1:0] current_mode;
        logic       mode_changed;
    } out_item_t;

    // Controller state apart from the hold counter, whose width is a parameter.
    typedef struct packed {
        mode_t                 mode;
        logic [CFG_DATA_W-1:0] debounce_left;
        logic                  prev_mode_level;
        logic                  prev_start_level;
    } ctrl_state_t;

    typedef struct packed {
        logic [CFG_DATA_W-1:0] long_press_ticks;
        logic [CFG_DATA_W-1:0] debounce_ticks;
    } cfg_t;

endpackage

// ----- design/dmbc_step.sv -----
module dmbc_step
    import dmbc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  in_item_t               item,
    input  cfg_t                   cfg,
    input  ctrl_state_t            state,
    input  logic [COUNT_WIDTH-1:0] hold_count,
    output ctrl_state_t            state_next,
    output logic [COUNT_WIDTH-1:0] hold_count_next,
    output out_item_t              result
);

    localparam int CMP_W = (COUNT_WIDTH > CFG_DATA_W) ? COUNT_WIDTH : CFG_DATA_W;
    localparam logic [COUNT_WIDTH-1:0] HOLD_MAX = '1;

    logic                   in_estop;
    logic                   holding;
    logic [COUNT_WIDTH-1:0] hold_inc;
    logic                   long_hit;
    logic                   start_edge;
    logic                   mode_edge;
    logic                   changed;

    always_comb begin
        in_estop   = (state.mode == MODE_ESTOP);
        holding    = in_estop && item.mode_button;
        hold_inc   = (hold_count < HOLD_MAX) ? hold_count + 1'b1 : hold_count;
        long_hit   = holding &&
                     (CMP_W'(hold_inc) >= CMP_W'(cfg.long_press_ticks));
        start_edge = state.prev_start_level && !item.start_button && in_estop;
        mode_edge  = state.prev_mode_level && !item.mode_button && !in_estop;
    end

    always_comb begin
        state_next      = state;
        hold_count_next = hold_count;
        changed         = 1'b0;
        case (op_t'(item.operation))
            OP_TICK: begin
                if (long_hit) begin
                    state_next.mode          = MODE_MANUAL;
                    hold_count_next          = '0;
                    state_next.debounce_left = cfg.debounce_ticks;
                    changed                  = 1'b1;
                end else begin
                    hold_count_next = holding ? hold_inc : '0;
                    if (state.debounce_left != '0) begin
                        state_next.debounce_left = state.debounce_left - 1'b1;
                    end else if (start_edge) begin
                        state_next.mode          = MODE_MANUAL;
                        state_next.debounce_left = cfg.debounce_ticks;
                        changed                  = 1'b1;
                    end else if (mode_edge) begin
                        state_next.mode = (state.mode == MODE_MANUAL) ? MODE_AUTO
                                                                      : MODE_MANUAL;
                        state_next.debounce_left = cfg.debounce_ticks;
                        changed                  = 1'b1;
                    end
                end
                // levels are sampled on every tick except those swallowed by debounce
                if (long_hit || state.debounce_left == '0) begin
                    state_next.prev_mode_level  = item.mode_button;
                    state_next.prev_start_level = item.start_button;
                end
            end
            OP_ESTOP: begin
                state_next.mode = MODE_ESTOP;
            end
            OP_SET_MODE: begin
                if (item.bus_mode <= BUS_MODE_W'(MODE_ESTOP)) begin
                    state_next.mode = mode_t'(item.bus_mode[1:0]);
                end
            end
            default: begin
            end
        endcase
    end

    assign result.current_mode = state_next.mode;
    assign result.mode_changed = changed;

endmodule

// ----- design/drive_mode_button_controller.sv -----
// Drive mode controller: manual, auto and emergency stop, driven by button ticks.
// Input channel s_valid/s_ready/s_data carries one item per transfer: a tick with
// the MODE and START levels, a forced emergency stop, or a mode set from the bus.
// Result channel m_valid/m_ready/m_data returns exactly one result per item:
// the mode after the item and a flag set when a tick changed the mode.
// Config channel cfg_valid/cfg_ready/cfg_index/cfg_data writes long_press_ticks
// (index 0) and debounce_ticks (index 1); cfg_ready is always high. Write config
// only while no item is in flight.
// Path: an accepted item goes into the input register, then its result into the
// result register, which drives m_valid.
// Throughput: one item per cycle while m_ready is high; the whole update is one
// combinational pass between the two registers.
// Reset (synchronous, aresetn low): manual mode, counters cleared, stored button
// levels high, config back to 30 / 5, both pipeline registers empty.
// If the receiver stalls, the result holds in the output register, one more item
// waits in the input register, and s_ready drops until m_ready returns.
module drive_mode_button_controller
    import dmbc_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEFAULT
) (
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_item_t               s_data,

    output logic                   m_valid,
    input  logic                   m_ready,
    output out_item_t              m_data,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    cfg_t                   cfg_reg,  cfg_next;
    logic                   in_valid_reg, in_valid_next;
    in_item_t               in_data_reg;
    logic                   m_valid_reg, m_valid_next;
    out_item_t              m_data_reg;
    ctrl_state_t            state_reg, state_next;
    logic [COUNT_WIDTH-1:0] hold_reg, hold_next;
    out_item_t              result;
    logic                   advance;
    logic                   s_xfer;

    dmbc_step #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) u_step (
        .item            (in_data_reg),
        .cfg             (cfg_reg),
        .state           (state_reg),
        .hold_count      (hold_reg),
        .state_next      (state_next),
        .hold_count_next (hold_next),
        .result          (result)
    );

    assign advance   = in_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        m_valid_next = m_valid_reg;
        if (advance) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index_t'(cfg_index))
                CFG_LONG_PRESS: cfg_next.long_press_ticks = cfg_data;
                CFG_DEBOUNCE:   cfg_next.debounce_ticks   = cfg_data;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg                   <= 1'b0;
            m_valid_reg                    <= 1'b0;
            cfg_reg.long_press_ticks       <= LONG_PRESS_RESET;
            cfg_reg.debounce_ticks         <= DEBOUNCE_RESET;
            state_reg.mode                 <= MODE_MANUAL;
            state_reg.debounce_left        <= '0;
            state_reg.prev_mode_level      <= 1'b1;
            state_reg.prev_start_level     <= 1'b1;
            hold_reg                       <= '0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
            cfg_reg      <= cfg_next;
            if (advance) begin
                state_reg <= state_next;
                hold_reg  <= hold_next;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            m_data_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- design/dmbc_checker.sv -----
module dmbc_checker
    import dmbc_pkg::*;
(
    input logic      aclk,
    input logic      aresetn,
    input logic      s_ready,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_data
);

    // reset empties the result register
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed or dropped");

    // a ready receiver never backs up the input side
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_ready |-> s_ready)
        else $error("input stalled while receiver ready");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.current_mode != 2'd3)
        else $error("illegal mode code on result");

endmodule

bind drive_mode_button_controller dmbc_checker u_dmbc_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
